// File: hw/rtl/ffrt_pkg.sv
package ffrt_pkg;

   localparam int FLOW_COUNT    = 4;
   localparam int CHANNEL_COUNT = 2;
   localparam int BUFFER_WORDS  = 4096;
   localparam int ENTRY_COUNT   = FLOW_COUNT * CHANNEL_COUNT;
   localparam int ENTRY_W       = $clog2(ENTRY_COUNT);

   localparam int CHANNEL_W  = 1;
   localparam int FLOW_W     = 2;
   localparam int BUFS_W     = 16;
   localparam int OFFS_W     = 12;
   localparam int LEVEL_W    = 28;
   localparam int DIFF_W     = 29;
   localparam int LAG_W      = 16;
   localparam int RES_W      = 8;
   localparam int CODE_W     = 2;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 28;

   localparam logic [LEVEL_W-1:0] LEVEL_MIN_RESET       = 28'd10000;
   localparam logic [LEVEL_W-1:0] LEVEL_MAX_RESET       = 28'd30000;
   localparam logic [LEVEL_W-1:0] START_THRESHOLD_RESET = 28'd150000;
   localparam logic [LAG_W-1:0]   LAG_LIMIT_RESET       = 16'd500;
   localparam logic [RES_W-1:0]   MAX_LEVEL_RESET       = 8'd16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LEVEL_MIN       = 3'd0,
      CSR_LEVEL_MAX       = 3'd1,
      CSR_START_THRESHOLD = 3'd2,
      CSR_LAG_LIMIT       = 3'd3,
      CSR_MAX_LEVEL       = 3'd4
   } csr_index_type;

   typedef enum logic [CODE_W-1:0] {
      STEP_NONE = 2'd0,
      STEP_UP   = 2'd1,
      STEP_DOWN = 2'd2
   } step_type;

   typedef enum logic [CODE_W-1:0] {
      BAND_IN    = 2'd0,
      BAND_OVER  = 2'd1,
      BAND_UNDER = 2'd2
   } band_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_EVAL,
      ST_DECIDE
   } state_type;

   // offset an entry holds after reset: one on the right channel
   function automatic logic [OFFS_W-1:0] entry_reset_offset(input logic [ENTRY_W-1:0] idx);
      return ((int'(idx) / FLOW_COUNT) == 1) ? OFFS_W'(1) : OFFS_W'(0);
   endfunction

   function automatic logic [LEVEL_W-1:0] pos_level(input logic [BUFS_W-1:0] bufs,
                                                    input logic [OFFS_W-1:0] offs);
      logic [31:0] prod;
      prod = 32'(bufs) * 32'(BUFFER_WORDS);
      return LEVEL_W'(prod + 32'(offs));
   endfunction

endpackage

// File: hw/rtl/ffrt_req_if.sv
interface ffrt_req_if;
   import ffrt_pkg::*;

   logic                 valid;
   logic                 ready;
   logic                 action;
   logic [CHANNEL_W-1:0] channel;
   logic [FLOW_W-1:0]    flow_index;
   logic [BUFS_W-1:0]    read_buffers;
   logic [OFFS_W-1:0]    read_offset;
   logic [BUFS_W-1:0]    put_buffers;
   logic [OFFS_W-1:0]    put_offset;

   modport source (output valid, action, channel, flow_index, read_buffers, read_offset,
                   put_buffers, put_offset, input ready);
   modport sink (input valid, action, channel, flow_index, read_buffers, read_offset,
                 put_buffers, put_offset, output ready);
endinterface

// File: hw/rtl/ffrt_rsp_if.sv
interface ffrt_rsp_if;
   import ffrt_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [RES_W-1:0]     res_level;
   logic [DIFF_W-1:0]    fill_diff;
   logic [CODE_W-1:0]    step;
   logic [CODE_W-1:0]    out_of_band;

   modport source (output valid, res_level, fill_diff, step, out_of_band, input ready);
   modport sink (input valid, res_level, fill_diff, step, out_of_band, output ready);
endinterface

// File: hw/rtl/fifo_fill_resampler_tuner_core.sv
// sequence: a store is written to the position memory when accepted; a tune transaction
// reads all 8 position memory entries, then drains, subtracts and decides, stalling in decide
// acceptance: one store per cycle while idle; no request is taken until a tune is back in
// idle, since the single read port of the position memory walks all channel/flow entries
// reset: registers return to defaults, level, lags and read level clear, all positions
// read as their reset values at once through per-entry valid bits
module fifo_fill_resampler_tuner_core (
   input  logic                                clock,
   input  logic                                reset,
   ffrt_req_if.sink                            req_ch,
   ffrt_rsp_if.source                          rsp_ch,
   input  logic                                csr_we,
   input  logic [ffrt_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [ffrt_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import ffrt_pkg::*;

   // configuration
   logic [LEVEL_W-1:0] band_lo_ff, band_hi_ff, start_thr_ff;
   logic [LAG_W-1:0]   lag_limit_ff;
   logic [RES_W-1:0]   level_cap_ff;

   // control
   state_type           state_ff, state_in;
   logic [ENTRY_W-1:0]  cnt_ff, cnt_in;
   logic [ENTRY_COUNT-1:0] vld_ff;
   logic                rd_pend_ff;
   logic [ENTRY_W-1:0]  rd_idx_ff;

   // position memory
   logic [BUFS_W+OFFS_W-1:0] mem [ENTRY_COUNT];
   logic [BUFS_W+OFFS_W-1:0] mem_q_ff;
   logic                     vld_q_ff;

   // tuner state and work registers
   logic [LEVEL_W-1:0] write_lvl_ff, best_ff, read_level_ff;
   logic               found_ff;
   logic [DIFF_W-1:0]  diff_ff;
   logic [RES_W-1:0]   res_level_ff;
   logic [LAG_W-1:0]   over_lag_ff, under_lag_ff;

   // result register
   logic               rsp_valid_ff;
   logic [RES_W-1:0]   rsp_res_ff;
   logic [DIFF_W-1:0]  rsp_diff_ff;
   logic [CODE_W-1:0]  rsp_step_ff, rsp_band_ff;

   logic               req_ready;
   logic               accept, store_wr, tune_go, commit;
   logic [ENTRY_W-1:0] wr_idx;

   logic [BUFS_W-1:0]  ent_bufs;
   logic [OFFS_W-1:0]  ent_offs;
   logic [LEVEL_W-1:0] ent_level;
   logic               ent_better;
   logic [LEVEL_W-1:0] read_level_in;

   logic               started, is_over, is_under;
   logic [RES_W-1:0]   res_level_in;
   logic [LAG_W-1:0]   over_lag_in, under_lag_in;
   step_type           step_in;
   band_type           band_in;

   assign req_ch.ready = req_ready;
   assign accept   = req_ch.valid && req_ready;
   assign store_wr = accept && !req_ch.action && (int'(req_ch.channel) < CHANNEL_COUNT)
                     && (int'(req_ch.flow_index) < FLOW_COUNT);
   assign tune_go  = accept && req_ch.action;
   assign wr_idx   = ENTRY_W'(int'(req_ch.channel) * FLOW_COUNT + int'(req_ch.flow_index));

   // sequencer
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      req_ready = 1'b0;
      commit    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cnt_in    = '0;
            if (req_ch.valid && req_ch.action) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == ENTRY_W'(ENTRY_COUNT - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            // wait for room in the result register
            if (!rsp_valid_ff || rsp_ch.ready) begin
               commit   = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         band_lo_ff   <= LEVEL_MIN_RESET;
         band_hi_ff   <= LEVEL_MAX_RESET;
         start_thr_ff <= START_THRESHOLD_RESET;
         lag_limit_ff <= LAG_LIMIT_RESET;
         level_cap_ff <= MAX_LEVEL_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_LEVEL_MIN:       band_lo_ff   <= csr_wdata[LEVEL_W-1:0];
            CSR_LEVEL_MAX:       band_hi_ff   <= csr_wdata[LEVEL_W-1:0];
            CSR_START_THRESHOLD: start_thr_ff <= csr_wdata[LEVEL_W-1:0];
            CSR_LAG_LIMIT:       lag_limit_ff <= csr_wdata[LAG_W-1:0];
            CSR_MAX_LEVEL:       level_cap_ff <= csr_wdata[RES_W-1:0];
            default: ;
         endcase
      end
   end

   // position memory, one write and one registered read port
   always_ff @(posedge clock) begin
      if (store_wr) begin
         mem[wr_idx] <= {req_ch.read_buffers, req_ch.read_offset};
      end
      if (state_ff == ST_SCAN) begin
         mem_q_ff <= mem[cnt_ff];
         vld_q_ff <= vld_ff[cnt_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         rd_pend_ff <= 1'b0;
         rd_idx_ff  <= '0;
      end else begin
         if (store_wr) begin
            vld_ff[wr_idx] <= 1'b1;
         end
         rd_pend_ff <= (state_ff == ST_SCAN);
         rd_idx_ff  <= cnt_ff;
      end
   end

   // compare the entry read last cycle against the running best
   always_comb begin
      ent_bufs   = vld_q_ff ? mem_q_ff[BUFS_W+OFFS_W-1:OFFS_W] : '0;
      ent_offs   = vld_q_ff ? mem_q_ff[OFFS_W-1:0] : entry_reset_offset(rd_idx_ff);
      ent_level  = pos_level(ent_bufs, ent_offs);
      ent_better = rd_pend_ff && ((ent_bufs != '0) || (ent_offs != '0))
                   && (ent_level > best_ff);
   end

   assign read_level_in = found_ff ? best_ff : read_level_ff;

   // level step decision
   always_comb begin
      started      = read_level_ff > start_thr_ff;
      is_over      = $signed(diff_ff) > $signed({1'b0, band_hi_ff});
      is_under     = $signed(diff_ff) < $signed({1'b0, band_lo_ff});
      res_level_in = res_level_ff;
      over_lag_in  = over_lag_ff;
      under_lag_in = under_lag_ff;
      step_in      = STEP_NONE;
      band_in      = BAND_IN;
      if (started) begin
         priority if (is_over) begin
            band_in = BAND_OVER;
            if (res_level_ff < level_cap_ff && over_lag_ff > lag_limit_ff) begin
               res_level_in = res_level_ff + 1'b1;
               over_lag_in  = '0;
               step_in      = STEP_UP;
            end else if (over_lag_ff != '1) begin
               over_lag_in = over_lag_ff + 1'b1;
            end
         end else if (is_under) begin
            band_in = BAND_UNDER;
            if (res_level_ff != '0 && under_lag_ff > lag_limit_ff) begin
               res_level_in = res_level_ff - 1'b1;
               under_lag_in = '0;
               step_in      = STEP_DOWN;
            end else if (under_lag_ff != '1) begin
               under_lag_in = under_lag_ff + 1'b1;
            end
         end else begin
            band_in = BAND_IN;
         end
      end
   end

   // tuner state
   always_ff @(posedge clock) begin
      if (reset) begin
         read_level_ff <= '0;
         res_level_ff  <= '0;
         over_lag_ff   <= '0;
         under_lag_ff  <= '0;
         found_ff      <= 1'b0;
         best_ff       <= '0;
      end else begin
         if (tune_go) begin
            found_ff <= 1'b0;
            best_ff  <= '0;
         end else if (ent_better) begin
            found_ff <= 1'b1;
            best_ff  <= ent_level;
         end
         if (state_ff == ST_EVAL) begin
            read_level_ff <= read_level_in;
         end
         if (commit) begin
            res_level_ff <= res_level_in;
            over_lag_ff  <= over_lag_in;
            under_lag_ff <= under_lag_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (tune_go) begin
         write_lvl_ff <= pos_level(req_ch.put_buffers, req_ch.put_offset);
      end
      if (state_ff == ST_EVAL) begin
         diff_ff <= DIFF_W'({1'b0, write_lvl_ff}) - DIFF_W'({1'b0, read_level_in});
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         rsp_res_ff  <= res_level_in;
         rsp_diff_ff <= diff_ff;
         rsp_step_ff <= step_in;
         rsp_band_ff <= band_in;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.res_level   = rsp_res_ff;
   assign rsp_ch.fill_diff   = rsp_diff_ff;
   assign rsp_ch.step        = rsp_step_ff;
   assign rsp_ch.out_of_band = rsp_band_ff;

endmodule
